// File: rtl/rrdr_pkg.sv
// ----------------------------------------------------------------------------
// rrdr_pkg
// Types, register indexes and reset values for the displacement relocator.
// ----------------------------------------------------------------------------
package rrdr_pkg;

    localparam int LINE_DEPTH = 7;

    typedef logic [7:0] t_byte;
    typedef logic [LINE_DEPTH-1:0][7:0] t_line;

    // register indexes on the configuration channel
    localparam logic [7:0] REG_OPCODE_FIRST  = 8'd0;
    localparam logic [7:0] REG_OPCODE_SECOND = 8'd1;
    localparam logic [7:0] REG_OPCODE_THIRD  = 8'd2;
    localparam logic [7:0] REG_TWO_BYTE_MODE = 8'd3;
    localparam logic [7:0] REG_LOAD_BASE     = 8'd4;
    localparam logic [7:0] REG_WINDOW_START  = 8'd5;
    localparam logic [7:0] REG_WINDOW_LENGTH = 8'd6;
    localparam logic [7:0] REG_DEST_START    = 8'd7;

    localparam logic [7:0]  RST_OPCODE_FIRST  = 8'h48;
    localparam logic [7:0]  RST_OPCODE_SECOND = 8'h8D;
    localparam logic [7:0]  RST_OPCODE_THIRD  = 8'h05;
    localparam logic        RST_TWO_BYTE_MODE = 1'b0;
    localparam logic [31:0] RST_LOAD_BASE     = 32'h0060_0000;
    localparam logic [31:0] RST_WINDOW_START  = 32'h0000_0000;
    localparam logic [26:0] RST_WINDOW_LENGTH = 27'd0;
    localparam logic [31:0] RST_DEST_START    = 32'h00E0_0000;

    // instruction length: opcode plus four displacement bytes
    localparam logic [2:0] NEED_TWO   = 3'd6;
    localparam logic [2:0] NEED_THREE = 3'd7;

    typedef struct packed {
        t_byte in_byte;
        logic  in_last;
    } t_in_item;

    typedef struct packed {
        t_byte out_byte;
        logic  out_last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  cfg_index;
        logic [31:0] cfg_value;
    } t_cfg_req;

    // settings as the scanner sees them, with address sums folded in
    typedef struct packed {
        t_byte       opcode_first;
        t_byte       opcode_second;
        t_byte       opcode_third;
        logic        two_byte_mode;
        logic [31:0] off_base;      // load_base - window_start + need
        logic [31:0] disp_base;     // dest_start - window_start
        logic [26:0] window_length;
    } t_scan_cfg;

    typedef struct packed {
        t_line      line;
        logic [2:0] avail;
        logic [2:0] skip;
    } t_scan_in;

    typedef struct packed {
        t_byte      head;
        t_line      line;
        logic [2:0] skip;
    } t_scan_out;

endpackage

// File: rtl/rrdr_chan_if.sv
// ----------------------------------------------------------------------------
// rrdr_chan_if
// Valid/ready channel carrying one request payload of type T.
// ----------------------------------------------------------------------------
interface rrdr_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/rrdr_scan.sv
// ----------------------------------------------------------------------------
// rrdr_scan
// Match check and displacement patch on the head of the delay line, then
// shift of the line by one byte.
// ----------------------------------------------------------------------------
module rrdr_scan #(
    parameter int POSITION_BITS = 26
) (
    input  rrdr_pkg::t_scan_cfg        i_cfg,
    input  rrdr_pkg::t_scan_in         i_scan,
    input  logic [POSITION_BITS-1:0]   i_pos,
    output rrdr_pkg::t_scan_out        o_scan
);
    import rrdr_pkg::*;

    logic [2:0]  need;
    logic        match;
    logic [31:0] disp;
    logic [31:0] offset;
    logic [31:0] patch_disp;
    logic        in_window;
    t_line       patched;

    always_comb begin
        need  = i_cfg.two_byte_mode ? NEED_TWO : NEED_THREE;
        match = (i_scan.avail >= need) &&
                (i_scan.line[0] == i_cfg.opcode_first) &&
                (i_scan.line[1] == i_cfg.opcode_second) &&
                (i_cfg.two_byte_mode || (i_scan.line[2] == i_cfg.opcode_third));

        if (i_cfg.two_byte_mode) begin
            disp = {i_scan.line[5], i_scan.line[4], i_scan.line[3], i_scan.line[2]};
        end else begin
            disp = {i_scan.line[6], i_scan.line[5], i_scan.line[4], i_scan.line[3]};
        end

        // target - window_start, with the constant part precomputed
        offset    = i_cfg.off_base + 32'(i_pos) + disp;
        in_window = offset < {5'd0, i_cfg.window_length};
        // dest + offset - next reduces to this
        patch_disp = i_cfg.disp_base + disp;

        patched = i_scan.line;
        if ((i_scan.skip == 3'd0) && match && in_window) begin
            if (i_cfg.two_byte_mode) begin
                patched[2] = patch_disp[7:0];
                patched[3] = patch_disp[15:8];
                patched[4] = patch_disp[23:16];
                patched[5] = patch_disp[31:24];
            end else begin
                patched[3] = patch_disp[7:0];
                patched[4] = patch_disp[15:8];
                patched[5] = patch_disp[23:16];
                patched[6] = patch_disp[31:24];
            end
        end

        if (i_scan.skip != 3'd0) begin
            o_scan.skip = i_scan.skip - 3'd1;
        end else if (match) begin
            o_scan.skip = need - 3'd1;
        end else begin
            o_scan.skip = 3'd0;
        end

        o_scan.head = i_scan.line[0];
        for (int k = 0; k < LINE_DEPTH - 1; k++) begin
            o_scan.line[k] = patched[k+1];
        end
        o_scan.line[LINE_DEPTH-1] = 8'd0;
    end

endmodule

// File: rtl/rip_relative_displacement_relocator_unit.sv
// ----------------------------------------------------------------------------
// rip_relative_displacement_relocator_unit
// Byte stream relocator: rewrites 32-bit relative displacements after a
// configured opcode when their target falls in the moved window.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                     | request moves
//  ---------+-----+-----------------------------+---------------------------
//  i_in     | in  | in_byte[7:0], in_last       | one stream byte
//  o_out    | out | out_byte[7:0], out_last     | one stream byte
//  i_cfg    | in  | cfg_index[7:0], cfg_value   | one register write
//
//  Sustained rate is one byte per cycle while the output is not stalled; the
//  first byte leaves once seven are held in the delay line, and the head check
//  sits between line and output register. A request with in_last drains the
//  line at one byte per cycle while the output is taken, with i_in held off until it is empty.
//  A stalled output register is refilled in the same cycle it is taken.
//  Synchronous reset clears the line, skip count and position, and restores the settings to their reset values.
// ----------------------------------------------------------------------------
module rip_relative_displacement_relocator_unit #(
    parameter int POSITION_BITS = 26
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rrdr_chan_if.sink          i_in,
    rrdr_chan_if.source        o_out,
    rrdr_chan_if.sink          i_cfg
);
    import rrdr_pkg::*;

    // settings
    t_byte       r_opc_first,  n_opc_first;
    t_byte       r_opc_second, n_opc_second;
    t_byte       r_opc_third,  n_opc_third;
    logic        r_two_byte,   n_two_byte;
    logic [31:0] r_load_base,  n_load_base;
    logic [31:0] r_win_start,  n_win_start;
    logic [26:0] r_win_len,    n_win_len;
    logic [31:0] r_dest_start, n_dest_start;
    logic [31:0] r_off_base,   n_off_base;
    logic [31:0] r_disp_base,  n_disp_base;

    // line state
    t_line                    r_line,  n_line;
    logic [2:0]               r_count, n_count;
    logic [2:0]               r_skip,  n_skip;
    logic [POSITION_BITS-1:0] r_pos,   n_pos;
    logic                     r_drain, n_drain;

    // output register
    logic  r_out_valid, n_out_valid;
    t_byte r_out_byte,  n_out_byte;
    logic  r_out_last,  n_out_last;

    t_scan_cfg  scan_cfg;
    t_scan_in   scan_in;
    t_scan_out  scan_out;
    logic       out_free;
    logic       emit_go;
    logic       in_go;
    logic       drain_end;
    logic [2:0] count_after;
    t_in_item   in_item;
    t_cfg_req   cfg_req;

    assign in_item = i_in.payload;
    assign cfg_req = i_cfg.payload;

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_opc_first  = r_opc_first;
        n_opc_second = r_opc_second;
        n_opc_third  = r_opc_third;
        n_two_byte   = r_two_byte;
        n_load_base  = r_load_base;
        n_win_start  = r_win_start;
        n_win_len    = r_win_len;
        n_dest_start = r_dest_start;
        if (i_cfg.valid) begin
            case (cfg_req.cfg_index)
                REG_OPCODE_FIRST:  n_opc_first  = cfg_req.cfg_value[7:0];
                REG_OPCODE_SECOND: n_opc_second = cfg_req.cfg_value[7:0];
                REG_OPCODE_THIRD:  n_opc_third  = cfg_req.cfg_value[7:0];
                REG_TWO_BYTE_MODE: n_two_byte   = cfg_req.cfg_value[0];
                REG_LOAD_BASE:     n_load_base  = cfg_req.cfg_value;
                REG_WINDOW_START:  n_win_start  = cfg_req.cfg_value;
                REG_WINDOW_LENGTH: n_win_len    = cfg_req.cfg_value[26:0];
                REG_DEST_START:    n_dest_start = cfg_req.cfg_value;
                default: ;
            endcase
        end
        // folded sums follow the new values so they are ready on the next edge
        n_off_base  = n_load_base - n_win_start +
                      {29'd0, (n_two_byte ? NEED_TWO : NEED_THREE)};
        n_disp_base = n_dest_start - n_win_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opc_first  <= RST_OPCODE_FIRST;
            r_opc_second <= RST_OPCODE_SECOND;
            r_opc_third  <= RST_OPCODE_THIRD;
            r_two_byte   <= RST_TWO_BYTE_MODE;
            r_load_base  <= RST_LOAD_BASE;
            r_win_start  <= RST_WINDOW_START;
            r_win_len    <= RST_WINDOW_LENGTH;
            r_dest_start <= RST_DEST_START;
            r_off_base   <= RST_LOAD_BASE - RST_WINDOW_START + {29'd0, NEED_THREE};
            r_disp_base  <= RST_DEST_START - RST_WINDOW_START;
        end else begin
            r_opc_first  <= n_opc_first;
            r_opc_second <= n_opc_second;
            r_opc_third  <= n_opc_third;
            r_two_byte   <= n_two_byte;
            r_load_base  <= n_load_base;
            r_win_start  <= n_win_start;
            r_win_len    <= n_win_len;
            r_dest_start <= n_dest_start;
            r_off_base   <= n_off_base;
            r_disp_base  <= n_disp_base;
        end
    end

    // ---------------- head check ----------------
    always_comb begin
        scan_cfg.opcode_first  = r_opc_first;
        scan_cfg.opcode_second = r_opc_second;
        scan_cfg.opcode_third  = r_opc_third;
        scan_cfg.two_byte_mode = r_two_byte;
        scan_cfg.off_base      = r_off_base;
        scan_cfg.disp_base     = r_disp_base;
        scan_cfg.window_length = r_win_len;
        scan_in.line  = r_line;
        scan_in.avail = r_count;
        scan_in.skip  = r_skip;
    end

    rrdr_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .i_cfg  (scan_cfg),
        .i_scan (scan_in),
        .i_pos  (r_pos),
        .o_scan (scan_out)
    );

    // ---------------- line and output control ----------------
    assign out_free  = !r_out_valid || o_out.ready;
    assign emit_go   = out_free && (r_drain ? (r_count != 3'd0)
                                            : (r_count == 3'(LINE_DEPTH)));
    assign drain_end = emit_go && r_drain && (r_count == 3'd1);
    assign i_in.ready = !r_drain && ((r_count != 3'(LINE_DEPTH)) || emit_go);
    assign in_go     = i_in.valid && i_in.ready;
    assign count_after = r_count - {2'd0, emit_go};

    always_comb begin
        n_line  = emit_go ? scan_out.line : r_line;
        n_count = count_after;
        n_skip  = emit_go ? scan_out.skip : r_skip;
        n_pos   = emit_go ? (r_pos + 1'b1) : r_pos;
        n_drain = r_drain;

        if (in_go) begin
            for (int k = 0; k < LINE_DEPTH; k++) begin
                if (3'(k) == count_after) begin
                    n_line[k] = in_item.in_byte;
                end
            end
            n_count = count_after + 3'd1;
            if (in_item.in_last) begin
                n_drain = 1'b1;
            end
        end

        // end of stream: back to the reset state
        if (drain_end) begin
            n_line  = '0;
            n_count = 3'd0;
            n_skip  = 3'd0;
            n_pos   = '0;
            n_drain = 1'b0;
        end

        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (emit_go) begin
            n_out_valid = 1'b1;
            n_out_byte  = scan_out.head;
            n_out_last  = drain_end;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= '0;
            r_count     <= 3'd0;
            r_skip      <= 3'd0;
            r_pos       <= '0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_line      <= n_line;
            r_count     <= n_count;
            r_skip      <= n_skip;
            r_pos       <= n_pos;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.payload.out_byte = r_out_byte;
    assign o_out.payload.out_last = r_out_last;

`ifndef NO_ASSERTIONS
    // a drain always has bytes left to send
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_count != 3'd0))
        else $error("drain with empty line");

    // the final byte leaves the line empty and ready for a new stream
    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drain_end |=> ((r_count == 3'd0) && !r_drain && r_out_valid && r_out_last))
        else $error("line not cleared after final byte");

    // skip never runs past one instruction
    a_skip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip <= 3'd6)
        else $error("skip count out of range");

    // an empty line carries no scan state from an earlier stream
    a_empty_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 3'd0) |-> ((r_skip == 3'd0) && (r_pos == '0)))
        else $error("stale scan state on empty line");
`endif

endmodule

// File: bench/rip_relative_displacement_relocator_unit_tb.sv
// ----------------------------------------------------------------------------
// rip_relative_displacement_relocator_unit_tb
// Feeds code byte streams through the relocator and checks every output byte
// against a cycle-free model of the delay line and displacement patching.
// A short table of hand-built streams runs first. Random instruction streams
// follow under several register settings and handshake stall patterns.
// ----------------------------------------------------------------------------
module rip_relative_displacement_relocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrdr_pkg::*;

    localparam int          POSITION_BITS     = 26;
    localparam logic [7:0]  REG_BEYOND_LAST   = 8'd8;
    localparam logic [31:0] WINDOW_LENGTH_MAX = 32'h0400_0000;
    localparam int          SETTLE_CYCLES     = 12;
    localparam int          DRAIN_LIMIT       = 5000;
    localparam int          SEGMENTS          = 8;
    localparam int          SEGMENT_BYTES     = 32;
    localparam int          IDLE_HEAVY        = 70;
    localparam int          IDLE_LIGHT        = 8;
    localparam int          MAX_PRINTED       = 40;

    typedef struct packed {
        logic        is_write;
        logic [7:0]  reg_index;
        logic [31:0] reg_value;
        t_byte       code;
        logic        last;
        logic        pinned;
        t_byte       pinned_out;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    rrdr_chan_if #(.T(t_in_item))  in_if ();
    rrdr_chan_if #(.T(t_out_item)) out_if ();
    rrdr_chan_if #(.T(t_cfg_req))  cfg_if ();

    rip_relative_displacement_relocator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // settings as the block should hold them
    t_byte       set_op_first      = RST_OPCODE_FIRST;
    t_byte       set_op_second     = RST_OPCODE_SECOND;
    t_byte       set_op_third      = RST_OPCODE_THIRD;
    logic        set_two_byte      = RST_TWO_BYTE_MODE;
    logic [31:0] set_load_base     = RST_LOAD_BASE;
    logic [31:0] set_window_start  = RST_WINDOW_START;
    logic [26:0] set_window_length = RST_WINDOW_LENGTH;
    logic [31:0] set_dest_start    = RST_DEST_START;

    t_byte                    line_q [LINE_DEPTH] = '{default: '0};
    int                       line_fill = 0;
    int                       skip_left = 0;
    logic [POSITION_BITS-1:0] head_pos  = '0;

    t_out_item expected_bytes[$];
    t_stim_row directed_rows[$];

    logic  pin_next  = 1'b0;
    t_byte pin_value = '0;

    int send_pct       = 0;
    int stall_pct      = 0;
    int error_count    = 0;
    int bytes_sent     = 0;
    int bytes_checked  = 0;
    int streams_sent   = 0;
    int settings_used  = 1;
    int rewrite_count  = 0;
    int seg_start;
    logic prev_write;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("timeout: stream did not complete");
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic t_byte opcode_byte(int k);
        return (k == 0) ? set_op_first : (k == 1) ? set_op_second : set_op_third;
    endfunction

    // head check and shift out of the oldest byte
    function automatic t_byte take_oldest(int avail);
        int          oplen;
        int          need;
        int          k;
        logic [31:0] disp;
        logic [31:0] next_pc;
        logic [31:0] target;
        logic [31:0] offset;
        logic [31:0] patch_disp;
        t_byte       head;
        oplen = set_two_byte ? 2 : 3;
        need  = oplen + 4;
        if (skip_left > 0) begin
            skip_left--;
        end else if (avail >= need && line_q[0] == set_op_first &&
                     line_q[1] == set_op_second &&
                     (set_two_byte || line_q[2] == set_op_third)) begin
            disp    = {line_q[oplen+3], line_q[oplen+2], line_q[oplen+1], line_q[oplen]};
            next_pc = set_load_base + 32'(head_pos) + 32'(need);
            target  = next_pc + disp;
            offset  = target - set_window_start;
            if (offset < {5'd0, set_window_length}) begin
                patch_disp = set_dest_start + offset - next_pc;
                for (k = 0; k < 4; k++)
                    line_q[oplen+k] = patch_disp[8*k +: 8];
                rewrite_count++;
            end
            skip_left = need - 1;
        end
        head = line_q[0];
        for (k = 0; k < LINE_DEPTH - 1; k++)
            line_q[k] = line_q[k+1];
        line_q[LINE_DEPTH-1] = '0;
        line_fill--;
        head_pos++;
        return head;
    endfunction

    task automatic relocate_byte(t_byte code, logic last);
        int        first_new;
        t_out_item item;
        first_new = expected_bytes.size();
        if (line_fill >= LINE_DEPTH) begin
            item.out_byte = take_oldest(line_fill);
            item.out_last = 1'b0;
            expected_bytes.push_back(item);
        end
        line_q[line_fill] = code;
        line_fill++;
        if (!last) begin
            if (line_fill == LINE_DEPTH) begin
                item.out_byte = take_oldest(line_fill);
                item.out_last = 1'b0;
                expected_bytes.push_back(item);
            end
        end else begin
            while (line_fill > 0) begin
                item.out_byte = take_oldest(line_fill);
                item.out_last = (line_fill == 0);
                expected_bytes.push_back(item);
            end
            line_q    = '{default: '0};
            skip_left = 0;
            head_pos  = '0;
        end
        if (pin_next && expected_bytes.size() > first_new)
            expected_bytes[first_new].out_byte = pin_value;
    endtask

    task automatic apply_setting(logic [7:0] reg_index, logic [31:0] value);
        case (reg_index)
            REG_OPCODE_FIRST:  set_op_first      = value[7:0];
            REG_OPCODE_SECOND: set_op_second     = value[7:0];
            REG_OPCODE_THIRD:  set_op_third      = value[7:0];
            REG_TWO_BYTE_MODE: set_two_byte      = value[0];
            REG_LOAD_BASE:     set_load_base     = value;
            REG_WINDOW_START:  set_window_start  = value;
            REG_WINDOW_LENGTH: set_window_length = value[26:0];
            REG_DEST_START:    set_dest_start    = value;
            default: ;
        endcase
    endtask

    task automatic compare_output(t_out_item got);
        t_out_item want;
        bytes_checked++;
        if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("output %0d: byte %02h last %0b with nothing expected",
                                      bytes_checked, got.out_byte, got.out_last));
            return;
        end
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("output %0d: out_byte %02h, want %02h",
                                      bytes_checked, got.out_byte, want.out_byte));
        if (got.out_last !== want.out_last)
            report_mismatch($sformatf("output %0d: out_last %0b, want %0b",
                                      bytes_checked, got.out_last, want.out_last));
    endtask

    // prediction runs before the output check so queue order holds
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                apply_setting(cfg_if.payload.cfg_index, cfg_if.payload.cfg_value);
            if (in_if.valid && in_if.ready)
                relocate_byte(in_if.payload.in_byte, in_if.payload.in_last);
            if (out_if.valid && out_if.ready)
                compare_output(out_if.payload);
        end
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_byte(t_byte code, logic last, logic pinned = 1'b0,
                             t_byte pinned_out = '0);
        t_in_item req;
        while ($urandom_range(99) < send_pct) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        pin_next     = pinned;
        pin_value    = pinned_out;
        req.in_byte  = code;
        req.in_last  = last;
        in_if.payload <= req;
        in_if.valid   <= 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        bytes_sent++;
    endtask

    task automatic write_setting(logic [7:0] reg_index, logic [31:0] value);
        t_cfg_req req;
        req.cfg_index = reg_index;
        req.cfg_value = value;
        @(negedge i_clk);
        cfg_if.payload <= req;
        cfg_if.valid   <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // wait for every expected byte, then let the line go quiet
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_stim_row write_row(logic [7:0] reg_index, logic [31:0] value);
        t_stim_row r;
        r           = '0;
        r.is_write  = 1'b1;
        r.reg_index = reg_index;
        r.reg_value = value;
        return r;
    endfunction

    function automatic t_stim_row byte_row(t_byte code, logic last = 1'b0,
                                           logic pinned = 1'b0, t_byte pinned_out = '0);
        t_stim_row r;
        r            = '0;
        r.code       = code;
        r.last       = last;
        r.pinned     = pinned;
        r.pinned_out = pinned_out;
        return r;
    endfunction

    task automatic random_settings(int seg);
        logic [31:0] len;
        if (seg == 0) begin
            write_setting(REG_OPCODE_FIRST, 32'h0);
            write_setting(REG_OPCODE_SECOND, 32'h0);
            write_setting(REG_OPCODE_THIRD, 32'h0);
            write_setting(REG_TWO_BYTE_MODE, 32'h0);
            write_setting(REG_LOAD_BASE, 32'h0);
            write_setting(REG_WINDOW_START, 32'h0);
            write_setting(REG_WINDOW_LENGTH, 32'h0);
            write_setting(REG_DEST_START, 32'h0);
        end else if (seg == 1) begin
            write_setting(REG_OPCODE_FIRST, 32'hFF);
            write_setting(REG_OPCODE_SECOND, 32'hFF);
            write_setting(REG_OPCODE_THIRD, 32'hFF);
            write_setting(REG_TWO_BYTE_MODE, 32'h1);
            write_setting(REG_LOAD_BASE, 32'hFFFF_FFFF);
            write_setting(REG_WINDOW_START, 32'hFFFF_FFFF);
            write_setting(REG_WINDOW_LENGTH, WINDOW_LENGTH_MAX);
            write_setting(REG_DEST_START, 32'hFFFF_FFFF);
        end else begin
            case ($urandom_range(3))
                0: len = $urandom_range(1, 256);
                1: len = WINDOW_LENGTH_MAX;
                default: len = $urandom_range(0, WINDOW_LENGTH_MAX);
            endcase
            write_setting(REG_OPCODE_FIRST, $urandom_range(0, 255));
            write_setting(REG_OPCODE_SECOND, $urandom_range(0, 255));
            write_setting(REG_OPCODE_THIRD, $urandom_range(0, 255));
            write_setting(REG_TWO_BYTE_MODE, $urandom_range(0, 1));
            write_setting(REG_LOAD_BASE, $urandom);
            write_setting(REG_WINDOW_START, $urandom);
            write_setting(REG_WINDOW_LENGTH, len);
            write_setting(REG_DEST_START, $urandom);
            if ($urandom_range(2) == 0)
                write_setting(8'(REG_BEYOND_LAST + $urandom_range(0, 247)), $urandom);
        end
    endtask

    // mostly whole instructions with random displacements, some noise
    task automatic random_stream();
        t_byte       code[$];
        int          span;
        int          oplen;
        int          at;
        int          k;
        logic [31:0] next_pc;
        logic [31:0] target;
        logic [31:0] disp;
        logic        done;
        span  = $urandom_range(1, 24);
        oplen = set_two_byte ? 2 : 3;
        done  = 1'b0;
        while (code.size() < span && !done) begin
            at = code.size();
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    next_pc = set_load_base + 32'(at + oplen + 4);
                    case ($urandom_range(6))
                        0: target = set_window_start;
                        1: target = set_window_start + {5'd0, set_window_length} - 1;
                        2: target = set_window_start + {5'd0, set_window_length};
                        3: target = set_window_start - 1;
                        4: target = $urandom;
                        default: target = (set_window_length == 0) ? $urandom :
                            set_window_start + $urandom_range(0, set_window_length - 1);
                    endcase
                    disp = target - next_pc;
                    for (k = 0; k < oplen; k++)
                        code.push_back(opcode_byte(k));
                    for (k = 0; k < 4; k++)
                        code.push_back(disp[8*k +: 8]);
                end
                6: begin
                    // stream ends inside an instruction
                    for (k = 0; k < oplen; k++)
                        code.push_back(opcode_byte(k));
                    repeat ($urandom_range(0, 3)) code.push_back(8'($urandom));
                    done = 1'b1;
                end
                7: begin
                    for (k = 0; k < $urandom_range(1, oplen - 1); k++)
                        code.push_back(opcode_byte(k));
                end
                default: code.push_back(8'($urandom));
            endcase
        end
        foreach (code[i])
            send_byte(code[i], i == code.size() - 1);
        streams_sent++;
    endtask

    initial begin
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;

        // reset settings: lone final byte
        directed_rows.push_back(byte_row(8'hFF, 1'b1, 1'b1, 8'hFF));
        // three-byte opcode whose target falls in the window
        directed_rows.push_back(write_row(REG_WINDOW_START, 32'h0060_0000));
        directed_rows.push_back(write_row(REG_WINDOW_LENGTH, 32'h0000_1000));
        directed_rows.push_back(byte_row(8'h48));
        directed_rows.push_back(byte_row(8'h8D));
        directed_rows.push_back(byte_row(8'h05));
        directed_rows.push_back(byte_row(8'h10));
        directed_rows.push_back(byte_row(8'h00));
        directed_rows.push_back(byte_row(8'h00));
        directed_rows.push_back(byte_row(8'h00, 1'b1, 1'b1, 8'h48));
        // match cut off by the end of the stream
        directed_rows.push_back(byte_row(8'h48));
        directed_rows.push_back(byte_row(8'h8D));
        directed_rows.push_back(byte_row(8'h05));
        directed_rows.push_back(byte_row(8'h01));
        directed_rows.push_back(byte_row(8'h02));
        directed_rows.push_back(byte_row(8'h03, 1'b1));
        // two-byte mode, top of address space, a 0x0400_0000-byte window
        directed_rows.push_back(write_row(REG_OPCODE_FIRST, 32'hFF));
        directed_rows.push_back(write_row(REG_OPCODE_SECOND, 32'h00));
        directed_rows.push_back(write_row(REG_OPCODE_THIRD, 32'hFF));
        directed_rows.push_back(write_row(REG_TWO_BYTE_MODE, 32'h1));
        directed_rows.push_back(write_row(REG_LOAD_BASE, 32'hFFFF_FFFF));
        directed_rows.push_back(write_row(REG_WINDOW_START, 32'h0));
        directed_rows.push_back(write_row(REG_WINDOW_LENGTH, WINDOW_LENGTH_MAX));
        directed_rows.push_back(write_row(REG_DEST_START, 32'hFFFF_FFFF));
        directed_rows.push_back(write_row(REG_BEYOND_LAST, 32'hFFFF_FFFF));
        // negative displacement wrapping into the window
        directed_rows.push_back(byte_row(8'hFF));
        directed_rows.push_back(byte_row(8'h00));
        directed_rows.push_back(byte_row(8'hFD));
        directed_rows.push_back(byte_row(8'hFF));
        directed_rows.push_back(byte_row(8'hFF));
        directed_rows.push_back(byte_row(8'hFF, 1'b1));
        // most negative displacement, target far outside
        directed_rows.push_back(byte_row(8'hFF));
        directed_rows.push_back(byte_row(8'h00));
        directed_rows.push_back(byte_row(8'h00));
        directed_rows.push_back(byte_row(8'h00));
        directed_rows.push_back(byte_row(8'h00));
        directed_rows.push_back(byte_row(8'h80));
        directed_rows.push_back(byte_row(8'hFF, 1'b1, 1'b1, 8'hFF));

        wait (i_rst_n === 1'b1);
        prev_write = 1'b1;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_write) begin
                if (!prev_write) begin
                    settle();
                    settings_used++;
                end
                write_setting(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end else begin
                send_byte(directed_rows[i].code, directed_rows[i].last,
                          directed_rows[i].pinned, directed_rows[i].pinned_out);
            end
            prev_write = directed_rows[i].is_write;
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            random_settings(seg);
            settings_used++;
            case (seg % 4)
                0: begin send_pct = 0;          stall_pct = 0;          end
                1: begin send_pct = IDLE_HEAVY; stall_pct = 0;          end
                2: begin send_pct = 0;          stall_pct = IDLE_HEAVY; end
                default: begin send_pct = IDLE_LIGHT; stall_pct = IDLE_LIGHT; end
            endcase
            seg_start = bytes_sent;
            while (bytes_sent - seg_start < SEGMENT_BYTES)
                random_stream();
        end

        settle();
        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never came out",
                                      expected_bytes.size()));
        $display("sent %0d code bytes in %0d streams under %0d register settings",
                 bytes_sent, streams_sent, settings_used);
        $display("checked %0d output bytes, %0d displacements patched",
                 bytes_checked, rewrite_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: rip_relative_displacement_relocator_unit.f
rtl/rrdr_pkg.sv
rtl/rrdr_chan_if.sv
rtl/rrdr_scan.sv
rtl/rip_relative_displacement_relocator_unit.sv
bench/rip_relative_displacement_relocator_unit_tb.sv
